// ----- src/fccw_pkg.sv -----
// Package for the FAT cluster chain walker: table geometry, FAT32 mark values,
// status codes and the result record. No dependencies.
package fccw_pkg;

  localparam int unsigned TABLE_DEPTH = 4096;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EPOCH_W     = 8;

  localparam logic [31:0] MARK_EOC_LOW       = 32'h0FFF_FFF8;
  localparam logic [31:0] MARK_EOC_HIGH      = 32'h0FFF_FFFF;
  localparam logic [31:0] MARK_BAD           = 32'h0FFF_FFF7;
  localparam logic [31:0] MARK_FREE          = 32'h0000_0000;
  localparam logic [31:0] FIRST_DATA_CLUSTER = 32'd2;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_LOOP    = 2'd1,
    STATUS_BAD     = 2'd2,
    STATUS_INVALID = 2'd3
  } status_e;

  typedef struct packed {
    status_e          status;
    logic [31:0]      offending_value;
    logic [CNT_W-1:0] visit_count;
  } result_t;

endpackage

// ----- src/fccw_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module fccw_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/fccw_walk.sv -----
// Chain walk sequencer: follows table entries, keeps the epoch-tagged visited
// map in its own RAM and sweeps it clear. Depends on fccw_pkg and fccw_ram.
module fccw_walk (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         walk_i,
  input  logic [31:0]                  start_cluster_i,
  input  logic [fccw_pkg::CNT_W-1:0]   size_i,
  output logic                         tbl_re_o,
  output logic [fccw_pkg::ADDR_W-1:0]  tbl_raddr_o,
  input  logic [31:0]                  tbl_rdata_i,
  output logic                         busy_o,
  output logic                         done_o,
  output fccw_pkg::result_t            result_o
);
  import fccw_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EVAL
  } state_e;

  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;
  localparam logic [ADDR_W-1:0]  ADDR_LAST   = '1;

  state_e               state_q;
  logic [ADDR_W-1:0]    cur_q;
  logic [CNT_W-1:0]     len_q;
  logic [EPOCH_W-1:0]   epoch_q;
  logic [ADDR_W-1:0]    clr_q;
  logic                 done_q;
  result_t              result_q;

  logic                 vis_we;
  logic [ADDR_W-1:0]    vis_waddr;
  logic [EPOCH_W-1:0]   vis_wdata;
  logic [EPOCH_W-1:0]   vis_rdata;
  logic                 hit;
  logic                 is_eoc;
  logic                 is_bad;
  logic                 is_link;
  logic [CNT_W-1:0]     len_d;

  assign hit     = (vis_rdata == epoch_q);
  assign is_eoc  = (tbl_rdata_i >= MARK_EOC_LOW) && (tbl_rdata_i <= MARK_EOC_HIGH);
  assign is_bad  = (tbl_rdata_i == MARK_BAD);
  assign is_link = (tbl_rdata_i != MARK_FREE) && (tbl_rdata_i >= FIRST_DATA_CLUSTER)
                   && (tbl_rdata_i < 32'(size_i));
  assign len_d   = len_q + CNT_W'(1);

  always_comb begin
    vis_we    = 1'b0;
    vis_waddr = cur_q;
    vis_wdata = epoch_q;
    case (state_q)
      S_CLEAR: begin
        vis_we    = 1'b1;
        vis_waddr = clr_q;
        vis_wdata = '0;
      end
      S_EVAL: begin
        vis_we = !hit;
      end
      default: begin
        vis_we = 1'b0;
      end
    endcase
  end

  assign tbl_re_o    = (state_q == S_READ);
  assign tbl_raddr_o = cur_q;
  assign busy_o      = (state_q != S_IDLE);
  assign done_o      = done_q;
  assign result_o    = result_q;

  fccw_ram #(
    .WIDTH (EPOCH_W),
    .DEPTH (TABLE_DEPTH)
  ) u_visited (
    .clk_i   (clk_i),
    .we_i    (vis_we),
    .waddr_i (vis_waddr),
    .wdata_i (vis_wdata),
    .re_i    (tbl_re_o),
    .raddr_i (cur_q),
    .rdata_o (vis_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      cur_q    <= '0;
      len_q    <= '0;
      epoch_q  <= EPOCH_FIRST;
      clr_q    <= '0;
      done_q   <= 1'b0;
      result_q <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + ADDR_W'(1);
          if (clr_q == ADDR_LAST) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (walk_i) begin
            if (start_cluster_i < 32'(size_i)) begin
              cur_q   <= start_cluster_i[ADDR_W-1:0];
              len_q   <= '0;
              state_q <= S_READ;
            end else begin
              done_q   <= 1'b1;
              result_q <= '{status: STATUS_OK, offending_value: '0, visit_count: '0};
            end
          end
        end
        S_READ: begin
          state_q <= S_EVAL;
        end
        S_EVAL: begin
          if (!hit && !is_eoc && !is_bad && is_link) begin
            len_q   <= len_d;
            cur_q   <= tbl_rdata_i[ADDR_W-1:0];
            state_q <= S_READ;
          end else begin
            done_q <= 1'b1;
            if (hit) begin
              result_q <= '{status: STATUS_LOOP, offending_value: 32'(cur_q),
                            visit_count: len_q};
            end else if (is_eoc) begin
              result_q <= '{status: STATUS_OK, offending_value: '0, visit_count: len_d};
            end else if (is_bad) begin
              result_q <= '{status: STATUS_BAD, offending_value: 32'(cur_q),
                            visit_count: len_d};
            end else begin
              result_q <= '{status: STATUS_INVALID, offending_value: tbl_rdata_i,
                            visit_count: len_d};
            end
            if (epoch_q == EPOCH_LAST) begin
              epoch_q <= EPOCH_FIRST;
              clr_q   <= '0;
              state_q <= S_CLEAR;
            end else begin
              epoch_q <= epoch_q + EPOCH_W'(1);
              state_q <= S_IDLE;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/fat_cluster_chain_walker.sv -----
// Top level of the FAT cluster chain walker: size register, table RAM and
// load path. Depends on fccw_pkg, fccw_ram and fccw_walk.
//
//   channel   ports                                        taken at edge with
//   request   action_i, entry_*_i, start_cluster_i         start && !busy
//   result    status_o, offending_value_o, visit_count_o   done_o, one cycle
//   config    cfg_wdata_i                                  cfg_we_i
//
// A load request leaves busy low, so loads stream one per cycle while busy is low.
// A walk request whose start lies outside the table gives its result the next cycle
// with busy low; otherwise each table read passes a read state, then a check and
// mark state: one read per cluster visited, plus one more when a loop is found.
// After reset, and after every 255th walk that reads the table, a sweep
// clears the visited map with busy high. The receiver cannot stall: done_o pulses once.
module fat_cluster_chain_walker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        action_i,
  input  logic [11:0] entry_index_i,
  input  logic [31:0] entry_value_i,
  input  logic [31:0] start_cluster_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [31:0] offending_value_o,
  output logic [12:0] visit_count_o,
  input  logic        cfg_we_i,
  input  logic [12:0] cfg_wdata_i
);
  import fccw_pkg::*;

  localparam logic [12:0] SIZE_RESET = 13'(TABLE_DEPTH);

  logic [12:0]       table_entries_q;
  logic [CNT_W-1:0]  size_in_use;
  logic              accept;
  logic              load_we;
  logic              walk;
  logic              tbl_re;
  logic [ADDR_W-1:0] tbl_raddr;
  logic [31:0]       tbl_rdata;
  result_t           result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_entries_q <= SIZE_RESET;
    end else if (cfg_we_i) begin
      table_entries_q <= cfg_wdata_i;
    end
  end

  assign size_in_use = (32'(table_entries_q) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                            : CNT_W'(table_entries_q);

  assign accept  = start && !busy;
  assign load_we = accept && !action_i && (32'(entry_index_i) < TABLE_DEPTH);
  assign walk    = accept && action_i;

  fccw_ram #(
    .WIDTH (32),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (entry_index_i[ADDR_W-1:0]),
    .wdata_i (entry_value_i),
    .re_i    (tbl_re),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  fccw_walk u_walk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .walk_i          (walk),
    .start_cluster_i (start_cluster_i),
    .size_i          (size_in_use),
    .tbl_re_o        (tbl_re),
    .tbl_raddr_o     (tbl_raddr),
    .tbl_rdata_i     (tbl_rdata),
    .busy_o          (busy),
    .done_o          (done_o),
    .result_o        (result)
  );

  assign status_o          = result.status;
  assign offending_value_o = result.offending_value;
  assign visit_count_o     = 13'(result.visit_count);

endmodule

// ----- tb/tb_top.sv -----
// Self-checking bench for fat_cluster_chain_walker: streams table loads and chain
// walks over several table sizes and checks every walk outcome on the done strobe.
// Depends on fccw_pkg and the walker RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fccw_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned PHASES      = 12;

  typedef enum bit {ACT_LOAD = 1'b0, ACT_WALK = 1'b1} fat_action_e;
  typedef enum int unsigned {END_EOC, END_BAD, END_STRAY, END_LOOP} chain_end_e;

  typedef struct packed {
    fat_action_e act;
    logic [11:0] index;
    logic [31:0] value;
    logic [31:0] cluster;
  } fat_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        action_i = 1'b0;
  logic [11:0] entry_index_i = '0;
  logic [31:0] entry_value_i = '0;
  logic [31:0] start_cluster_i = '0;
  logic        done_o;
  logic [1:0]  status_o;
  logic [31:0] offending_value_o;
  logic [12:0] visit_count_o;
  logic        cfg_we_i = 1'b0;
  logic [12:0] cfg_wdata_i = '0;

  // planner copy of the table: keeps every walk on written entries
  logic [31:0] plan_table [TABLE_DEPTH];
  bit          plan_written [TABLE_DEPTH];
  logic [12:0] plan_size = 13'd4096;
  logic [31:0] fat_table [TABLE_DEPTH];
  logic [12:0] fat_size = 13'd4096;

  fat_req_t    req_q [$];
  result_t     walk_expect [$];
  fat_req_t    cur_req;
  int unsigned planned = 0;
  int unsigned idle_pct = 0;
  int unsigned gap_left = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;

  always #10 clk_i = ~clk_i;

  fat_cluster_chain_walker dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .action_i         (action_i),
    .entry_index_i    (entry_index_i),
    .entry_value_i    (entry_value_i),
    .start_cluster_i  (start_cluster_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .offending_value_o(offending_value_o),
    .visit_count_o    (visit_count_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  function automatic int unsigned in_use(input logic [12:0] sz);
    return (sz > TABLE_DEPTH) ? TABLE_DEPTH : int'(sz);
  endfunction

  // Walk from first over the planner or the predictor table; hole reports the
  // first unwritten entry the planner walk would read, or -1.
  function automatic result_t follow_chain(input bit on_plan, input logic [31:0] first,
                                           output int hole);
    bit          seen [TABLE_DEPTH];
    logic [31:0] cur;
    logic [31:0] nxt;
    int unsigned lim;
    int unsigned steps;
    result_t     res;
    lim = in_use(on_plan ? plan_size : fat_size);
    foreach (seen[i]) seen[i] = 1'b0;
    res.status          = STATUS_OK;
    res.offending_value = '0;
    hole  = -1;
    steps = 0;
    cur   = first;
    while (cur < lim) begin
      if (seen[cur]) begin
        res.status          = STATUS_LOOP;
        res.offending_value = cur;
        break;
      end
      if (on_plan && !plan_written[cur]) begin
        hole = int'(cur);
        break;
      end
      seen[cur] = 1'b1;
      steps++;
      nxt = on_plan ? plan_table[cur] : fat_table[cur];
      if (nxt >= MARK_EOC_LOW && nxt <= MARK_EOC_HIGH) break;
      if (nxt == MARK_BAD) begin
        res.status          = STATUS_BAD;
        res.offending_value = cur;
        break;
      end
      if (nxt != MARK_FREE && nxt >= FIRST_DATA_CLUSTER && nxt < lim) begin
        cur = nxt;
      end else begin
        res.status          = STATUS_INVALID;
        res.offending_value = nxt;
        break;
      end
    end
    res.visit_count = steps[CNT_W-1:0];
    return res;
  endfunction

  function automatic logic [31:0] pick_entry();
    int unsigned lim;
    lim = in_use(plan_size);
    case ($urandom_range(0, 7))
      0: return MARK_EOC_LOW + $urandom_range(0, 7);
      1: return MARK_BAD;
      2: return MARK_FREE;
      3, 4: return $urandom_range(0, lim + 1);
      5: return MARK_BAD - 1;
      6: return ($urandom_range(0, 1) != 0) ? MARK_EOC_HIGH + 1 : 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  task automatic plan_load(input logic [11:0] idx, input logic [31:0] val);
    fat_req_t r;
    r.act     = ACT_LOAD;
    r.index   = idx;
    r.value   = val;
    r.cluster = $urandom();
    plan_table[idx]   = val;
    plan_written[idx] = 1'b1;
    req_q = {req_q, r};
    planned++;
  endtask

  task automatic plan_walk(input logic [31:0] first);
    fat_req_t r;
    result_t  probe;
    int       hole;
    probe = follow_chain(1'b1, first, hole);
    while (hole >= 0) begin
      plan_load(hole[11:0], pick_entry());
      probe = follow_chain(1'b1, first, hole);
    end
    r.act     = ACT_WALK;
    r.index   = 12'($urandom());
    r.value   = $urandom();
    r.cluster = first;
    req_q = {req_q, r};
    planned++;
  endtask

  task automatic settle();
    while (req_q.size() != 0 || walk_expect.size() != 0 || start) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [12:0] sizes [PHASES];
    int unsigned pool [];
    int unsigned lim;
    int unsigned span;
    int unsigned len;
    int unsigned pick;
    int unsigned hold;
    int unsigned phase_end;
    logic [31:0] tail;
    sizes = '{13'd4096, 13'd0, 13'd1, 13'd2, 13'd3, 13'd8191, 13'd9, 13'd40, 13'd300,
              13'd4095, 13'd4097, 13'd64};
    sizes[8] = 13'($urandom_range(4, 4095));
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int p = 0; p < PHASES; p++) begin
      settle();
      cfg_we_i    <= 1'b1;
      cfg_wdata_i <= sizes[p];
      @(posedge clk_i);
      cfg_we_i  <= 1'b0;
      plan_size = sizes[p];
      fat_size  = sizes[p];
      lim       = in_use(sizes[p]);
      span      = (lim > 2) ? lim - 2 : 0;
      idle_pct  = (p == PHASES - 1 || p % 3 == 1) ? 0 : ((p % 3 == 0) ? 10 : 30);
      pool      = new[span];
      foreach (pool[i]) pool[i] = i + 2;
      if (p == 0) begin
        plan_load(12'd0, MARK_EOC_LOW);
        plan_walk(32'd0);
        plan_load(12'd1, MARK_EOC_HIGH);
        plan_walk(32'd1);
        plan_load(12'd4095, 32'hFFFF_FFFF);
        plan_walk(32'd4095);
        plan_load(12'd2, MARK_BAD);
        plan_walk(32'd2);
        plan_load(12'd3, MARK_FREE);
        plan_walk(32'd3);
        plan_load(12'd4, 32'd1);
        plan_walk(32'd4);
        plan_load(12'd5, 32'd6);
        plan_load(12'd6, 32'd5);
        plan_walk(32'd5);
        plan_load(12'd7, 32'd7);
        plan_walk(32'd7);
        plan_load(12'd8, 32'd4096);
        plan_walk(32'd8);
        plan_load(12'd9, MARK_BAD - 1);
        plan_walk(32'd9);
        plan_load(12'd10, 32'd4095);
        plan_walk(32'd10);
        plan_walk(32'd4096);
        plan_walk(32'hFFFF_FFFF);
      end
      phase_end = planned + 145;
      while (planned < phase_end) begin
        if (span != 0 && $urandom_range(0, 9) < 7) begin
          // link distinct clusters into a chain, close it, then walk it
          pick = $urandom_range(0, 49);
          if (pick < 44) len = $urandom_range(1, 8);
          else if (pick < 49) len = $urandom_range(9, 40);
          else len = $urandom_range(41, 300);
          if (len > span) len = span;
          for (int i = 0; i < len; i++) begin
            pick       = $urandom_range(i, span - 1);
            hold       = pool[i];
            pool[i]    = pool[pick];
            pool[pick] = hold;
          end
          for (int i = 0; i + 1 < len; i++) plan_load(12'(pool[i]), pool[i + 1]);
          case (chain_end_e'($urandom_range(0, 3)))
            END_EOC:  tail = MARK_EOC_LOW + $urandom_range(0, 7);
            END_BAD:  tail = MARK_BAD;
            END_LOOP: tail = pool[$urandom_range(0, len - 1)];
            default: begin
              case ($urandom_range(0, 4))
                0: tail = MARK_FREE;
                1: tail = 32'd1;
                2: tail = lim;
                3: tail = $urandom_range(32'hFFFF_FFFF, lim);
                default: tail = 32'hFFFF_FFFF;
              endcase
            end
          endcase
          plan_load(12'(pool[len - 1]), tail);
          plan_walk(($urandom_range(0, 4) != 0) ? pool[0] : pool[$urandom_range(0, len - 1)]);
        end else if ($urandom_range(0, 1) != 0) begin
          plan_load(12'($urandom_range(0, TABLE_DEPTH - 1)), pick_entry());
        end else begin
          case ($urandom_range(0, 5))
            0: plan_walk($urandom_range(0, 1));
            1: plan_walk((lim == 0) ? 32'd0 : lim - 1);
            2: plan_walk(lim);
            3: plan_walk(32'hFFFF_FFFF);
            4: plan_walk($urandom());
            default: plan_walk($urandom_range(0, lim));
          endcase
        end
      end
    end
    settle();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  always @(posedge clk_i) begin : drive_requests
    result_t outcome;
    int      stray;
    logic    go;
    if (rst_ni) begin
      if (start && !busy) begin
        if (cur_req.act == ACT_LOAD) begin
          fat_table[cur_req.index] = cur_req.value;
        end else begin
          outcome = follow_chain(1'b0, cur_req.cluster, stray);
          walk_expect = {walk_expect, outcome};
        end
      end
      if (!start || !busy) begin
        go = 1'b0;
        if (gap_left != 0) begin
          gap_left--;
        end else if (req_q.size() != 0) begin
          if ($urandom_range(0, 99) < idle_pct) begin
            gap_left = $urandom_range(0, 10);
          end else begin
            cur_req = req_q.pop_front();
            go      = 1'b1;
          end
        end
        start <= go;
        if (go) begin
          action_i        <= cur_req.act;
          entry_index_i   <= cur_req.index;
          entry_value_i   <= cur_req.value;
          start_cluster_i <= cur_req.cluster;
        end
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && done_o) begin
      if (walk_expect.size() == 0) begin
        $error("result with no walk pending: status %0d, offending_value 0x%08h",
               status_o, offending_value_o);
        errors++;
      end else begin
        want = walk_expect.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          errors++;
        end
        if (offending_value_o !== want.offending_value) begin
          $error("offending_value: expected 0x%08h, got 0x%08h",
                 want.offending_value, offending_value_o);
          errors++;
        end
        if (visit_count_o !== want.visit_count) begin
          $error("visit_count: expected %0d, got %0d", want.visit_count, visit_count_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule
